// ===== sv/rvg_pkg.sv =====
// Package for the RMS voice activity gate: widths, register indexes, reset values
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rvg_pkg;

   // Buffer and sample sizes
   localparam int MAX_BUFFER_FRAMES = 4096;
   localparam int SAMPLE_W          = 16;
   localparam int COUNT_LIMIT       = 2 * MAX_BUFFER_FRAMES;
   localparam int COUNT_W           = $clog2(COUNT_LIMIT + 1);
   localparam int SQUARE_W          = 2 * SAMPLE_W - 1;
   localparam int SUM_W             = 44;
   localparam int MEAN_W            = 2 * SAMPLE_W - 1;
   localparam int RMS_W             = 16;
   localparam int DEN_W             = 16;
   localparam int LEVEL_W           = 17;
   localparam int FULL_LEVEL        = 65536;
   localparam int TIME_W            = 32;

   // Iteration counts of the shared divider and the square root unit
   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = (MEAN_W + 1) / 2;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 18;
   localparam int THRESH_W    = 18;
   localparam int HANG_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_STEREO_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LISTEN_ENABLE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LEVEL_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_SCALE_RMS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HANGOVER_MS     = 3'd4;

   localparam logic signed [THRESH_W-1:0] THRESHOLD_RESET  = -18'sd1;
   localparam logic [DEN_W-1:0]           FULL_SCALE_RESET = 16'd5571;
   localparam logic [HANG_W-1:0]          HANGOVER_RESET   = 16'd1000;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic square_left;
      logic add_left;
      logic add_right;
      logic div_load_mean;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic div_load_scale;
      logic commit;
   } rvg_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic buffer_last;
      logic out_busy;
   } rvg_status_type;

endpackage

`default_nettype wire

// ===== sv/rvg_req_if.sv =====
// Input channel of the RMS voice activity gate: valid/ready plus one sample item.
// Depends on rvg_pkg.
`default_nettype none

interface rvg_req_if
   import rvg_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_left;
   logic signed [SAMPLE_W-1:0] sample_right;
   logic                       buffer_last;
   logic [TIME_W-1:0]          now_ms;

   modport source (output valid, sample_left, sample_right, buffer_last, now_ms,
                   input ready);
   modport sink   (input valid, sample_left, sample_right, buffer_last, now_ms,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/rvg_rsp_if.sv =====
// Result channel of the RMS voice activity gate: valid/ready plus one buffer result.
// Depends on rvg_pkg.
`default_nettype none

interface rvg_rsp_if
   import rvg_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [RMS_W-1:0] rms_level;
   logic             level_active;
   logic             recording_on;
   logic             keep_buffer;
   logic             segment_end;

   modport source (output valid, rms_level, level_active, recording_on, keep_buffer,
                   segment_end, input ready);
   modport sink   (input valid, rms_level, level_active, recording_on, keep_buffer,
                   segment_end, output ready);
endinterface

`default_nettype wire

// ===== sv/rvg_ctrl.sv =====
// Controller of the RMS voice activity gate: sequences accumulation, the shared
// divider, the square root and the gate decision. Depends on rvg_pkg.
`default_nettype none

module rvg_ctrl
   import rvg_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire rvg_status_type status,
   output rvg_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_LEFT,
      S_SQ_RIGHT,
      S_ADD_RIGHT,
      S_MEAN_LOAD,
      S_DIV_MEAN,
      S_SQRT_LOAD,
      S_SQRT,
      S_SCALE_LOAD,
      S_DIV_SCALE,
      S_DECIDE
   } state_type;

   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Decode commands and next state
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
            if (req_valid) state_in = S_SQ_LEFT;
         end
         S_SQ_LEFT: begin
            cmd.square_left = 1'b1;
            state_in        = S_SQ_RIGHT;
         end
         S_SQ_RIGHT: begin
            cmd.add_left = 1'b1;
            state_in     = S_ADD_RIGHT;
         end
         S_ADD_RIGHT: begin
            cmd.add_right = 1'b1;
            state_in      = status.buffer_last ? S_MEAN_LOAD : S_IDLE;
         end
         S_MEAN_LOAD: begin
            cmd.div_load_mean = 1'b1;
            cnt_in            = '0;
            state_in          = S_DIV_MEAN;
         end
         S_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_SQRT_LOAD;
         end
         S_SQRT_LOAD: begin
            cmd.sqrt_load = 1'b1;
            cnt_in        = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) state_in = S_SCALE_LOAD;
         end
         S_SCALE_LOAD: begin
            cmd.div_load_scale = 1'b1;
            cnt_in             = '0;
            state_in           = S_DIV_SCALE;
         end
         S_DIV_SCALE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // hold until the output register is free
            cmd.commit = !status.out_busy;
            if (!status.out_busy) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and iteration count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/rvg_datapath.sv =====
// Datapath of the RMS voice activity gate: configuration registers, square
// accumulator, shared restoring divider, square root, gate and output register.
// Depends on rvg_pkg.
`default_nettype none

module rvg_datapath
   import rvg_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rvg_cmd_type                cmd,
   output rvg_status_type                  status,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_write_data,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_left,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_right,
   input  wire logic                       req_buffer_last,
   input  wire logic [TIME_W-1:0]          req_now_ms,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic [RMS_W-1:0]                rsp_rms_level,
   output logic                            rsp_level_active,
   output logic                            rsp_recording_on,
   output logic                            rsp_keep_buffer,
   output logic                            rsp_segment_end
);

   // Configuration
   logic                       stereo_ff;
   logic                       listen_ff;
   logic signed [THRESH_W-1:0] threshold_ff;
   logic [DEN_W-1:0]           full_scale_ff;
   logic [HANG_W-1:0]          hangover_ff;

   // Item registers
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic                       last_ff;
   logic [TIME_W-1:0]          now_ff;

   // Accumulation
   logic [SQUARE_W-1:0] product_ff;
   logic                fits_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [COUNT_W-1:0]  count_ff;

   // Divider, root and gate state
   logic [SUM_W-1:0]  div_num_ff;
   logic [DEN_W-1:0]  div_rem_ff;
   logic [DEN_W-1:0]  div_den_ff;
   logic              zero_count_ff;
   logic [MEAN_W-1:0] root_x_ff;
   logic [MEAN_W:0]   root_res_ff;
   logic [MEAN_W-1:0] root_bit_ff;
   logic [RMS_W-1:0]  rms_ff;
   logic              recording_ff;
   logic [TIME_W-1:0] last_active_ff;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0] out_rms_ff;
   logic             out_active_ff, out_rec_ff, out_keep_ff, out_seg_ff;

   // Combinational terms
   logic [SAMPLE_W-1:0]   left_mag, right_mag, square_src;
   logic [2*SAMPLE_W-1:0] square_full;
   logic [COUNT_W-1:0]    item_samples;
   logic [COUNT_W:0]      count_next;
   logic [DEN_W:0]        rem_shift, rem_diff;
   logic                  rem_ge;
   logic [MEAN_W:0]       root_trial;
   logic                  root_ge;
   logic [LEVEL_W-1:0]    scaled;
   logic                  active, act_listen, rec_now, timeout;
   logic [TIME_W-1:0]     last_now, elapsed;

   // Magnitude and square of the selected sample
   assign left_mag    = left_ff[SAMPLE_W-1]  ? SAMPLE_W'(-left_ff)  : SAMPLE_W'(left_ff);
   assign right_mag   = right_ff[SAMPLE_W-1] ? SAMPLE_W'(-right_ff) : SAMPLE_W'(right_ff);
   assign square_src  = cmd.square_left ? left_mag : right_mag;
   assign square_full = square_src * square_src;

   // Sample count check against the buffer limit
   assign item_samples = stereo_ff ? COUNT_W'(2) : COUNT_W'(1);
   assign count_next   = {1'b0, count_ff} + {1'b0, item_samples};

   // One restoring divider step
   assign rem_shift = {div_rem_ff, div_num_ff[SUM_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, div_den_ff};
   assign rem_diff  = rem_shift - {1'b0, div_den_ff};

   // One square root digit
   assign root_trial = root_res_ff + {1'b0, root_bit_ff};
   assign root_ge    = {1'b0, root_x_ff} >= root_trial;

   // Clamp the scaled level and compare with the threshold
   assign scaled = (div_num_ff > SUM_W'(FULL_LEVEL)) ? LEVEL_W'(FULL_LEVEL)
                                                    : div_num_ff[LEVEL_W-1:0];
   assign active = $signed({2'b00, scaled}) > $signed({threshold_ff[THRESH_W-1], threshold_ff});

   // Recording and hangover decision
   assign act_listen = active & listen_ff;
   assign last_now   = act_listen ? now_ff : last_active_ff;
   assign rec_now    = recording_ff | act_listen;
   assign elapsed    = now_ff - last_now;
   assign timeout    = rec_now & (elapsed > {{(TIME_W-HANG_W){1'b0}}, hangover_ff});

   // Output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign status.buffer_last = last_ff;
   assign status.out_busy    = rsp_valid_ff & ~rsp_ready;

   // Control state: configuration, accumulator, recording state, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff      <= 1'b0;
         listen_ff      <= 1'b0;
         threshold_ff   <= THRESHOLD_RESET;
         full_scale_ff  <= FULL_SCALE_RESET;
         hangover_ff    <= HANGOVER_RESET;
         sum_ff         <= '0;
         count_ff       <= '0;
         recording_ff   <= 1'b0;
         last_active_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_STEREO_MODE:     stereo_ff     <= csr_write_data[0];
               REG_LISTEN_ENABLE:   listen_ff     <= csr_write_data[0];
               REG_LEVEL_THRESHOLD: threshold_ff  <= $signed(csr_write_data[THRESH_W-1:0]);
               REG_FULL_SCALE_RMS:  full_scale_ff <= csr_write_data[DEN_W-1:0];
               REG_HANGOVER_MS:     hangover_ff   <= csr_write_data[HANG_W-1:0];
               default: ;
            endcase
         end
         if (cmd.add_left && fits_ff) begin
            sum_ff   <= sum_ff + SUM_W'(product_ff);
            count_ff <= count_next[COUNT_W-1:0];
         end
         if (cmd.add_right && fits_ff && stereo_ff) begin
            sum_ff <= sum_ff + SUM_W'(product_ff);
         end
         // drop the finished buffer once the divider has it
         if (cmd.div_load_mean) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end
         if (cmd.commit) begin
            recording_ff   <= rec_now & ~timeout;
            last_active_ff <= last_now;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         left_ff  <= req_sample_left;
         right_ff <= req_sample_right;
         last_ff  <= req_buffer_last;
         now_ff   <= req_now_ms;
      end
      if (cmd.square_left) begin
         fits_ff <= count_next <= (COUNT_W+1)'(COUNT_LIMIT);
      end
      if (cmd.square_left || cmd.add_left) begin
         product_ff <= square_full[SQUARE_W-1:0];
      end

      // Shared divider: load mean or scale operands, then step
      if (cmd.div_load_mean) begin
         div_num_ff    <= sum_ff;
         div_den_ff    <= DEN_W'(count_ff);
         div_rem_ff    <= '0;
         zero_count_ff <= (count_ff == '0);
      end else if (cmd.div_load_scale) begin
         div_num_ff <= {{(SUM_W-RMS_W-16){1'b0}}, root_res_ff[RMS_W-1:0], 16'd0};
         div_den_ff <= (full_scale_ff == '0) ? DEN_W'(1) : full_scale_ff;
         div_rem_ff <= '0;
         rms_ff     <= root_res_ff[RMS_W-1:0];
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[SUM_W-2:0], rem_ge};
         div_rem_ff <= rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      end

      // Square root of the mean, two bits of the radicand per step
      if (cmd.sqrt_load) begin
         root_x_ff   <= zero_count_ff ? '0 : div_num_ff[MEAN_W-1:0];
         root_res_ff <= '0;
         root_bit_ff <= MEAN_W'(1) << (MEAN_W - 1);
      end else if (cmd.sqrt_step) begin
         if (root_ge) begin
            root_x_ff   <= root_x_ff - root_trial[MEAN_W-1:0];
            root_res_ff <= (root_res_ff >> 1) + {1'b0, root_bit_ff};
         end else begin
            root_res_ff <= root_res_ff >> 1;
         end
         root_bit_ff <= root_bit_ff >> 2;
      end

      if (cmd.commit) begin
         out_rms_ff    <= rms_ff;
         out_active_ff <= active;
         out_rec_ff    <= rec_now & ~timeout;
         out_keep_ff   <= rec_now & ~timeout;
         out_seg_ff    <= timeout;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rms_level    = out_rms_ff;
   assign rsp_level_active = out_active_ff;
   assign rsp_recording_on = out_rec_ff;
   assign rsp_keep_buffer  = out_keep_ff;
   assign rsp_segment_end  = out_seg_ff;

endmodule

`default_nettype wire

// ===== sv/rms_voice_activity_gate.sv =====
// RMS voice activity gate, top level: controller, datapath and channel wiring.
// An item not marked last is accepted, then squared and accumulated through the single
// 16x16 multiplier; no new item is accepted until that work is done.
// A last item goes on through two 44-step runs of the shared restoring divider and
// the 16-step square root, then waits until the output register is free.
// Reset is synchronous, active high: clears the accumulator and recording state
// and returns the configuration registers to their reset values.
`default_nettype none

module rms_voice_activity_gate
   import rvg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   rvg_req_if.sink                     req_bus,
   rvg_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   rvg_cmd_type    cmd;
   rvg_status_type status;
   logic           req_ready;

   // Sequence the work on each transaction
   rvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   // Arithmetic, configuration and result register
   rvg_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_sample_left  (req_bus.sample_left),
      .req_sample_right (req_bus.sample_right),
      .req_buffer_last  (req_bus.buffer_last),
      .req_now_ms       (req_bus.now_ms),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_rms_level    (rsp_bus.rms_level),
      .rsp_level_active (rsp_bus.level_active),
      .rsp_recording_on (rsp_bus.recording_on),
      .rsp_keep_buffer  (rsp_bus.keep_buffer),
      .rsp_segment_end  (rsp_bus.segment_end)
   );

   // Only one transaction in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("input accepted while an item is still in work");

   // A segment end closes the recording and drops the buffer
   a_seg_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.segment_end) |-> (!rsp_bus.keep_buffer && !rsp_bus.recording_on))
      else $error("segment end with buffer kept or recording still on");

   // A kept buffer belongs to an ongoing recording
   a_keep_rec: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.keep_buffer) |-> rsp_bus.recording_on)
      else $error("buffer kept while not recording");

   // The level never exceeds full scale of a 16-bit sample
   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.rms_level <= 16'd32768))
      else $error("rms level out of range");

endmodule

`default_nettype wire
